// ===== src/tscb_pkg.sv =====
// ----------------------------------------------------------------------------
// tscb_pkg
// Shared constants and command codes for the text screen cursor buffer.
// ----------------------------------------------------------------------------
package tscb_pkg;

  // Default storage size
  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 128;

  // Register reset values
  localparam logic [5:0] RESET_HEIGHT = 6'd24;
  localparam logic [7:0] RESET_WIDTH  = 8'd80;
  localparam logic [7:0] RESET_BG     = 8'd32;

  localparam logic [7:0] NUL_CHAR = 8'd0;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_HEIGHT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_BG     = 2'd2
  } cfg_idx_t;

  // Command codes
  typedef enum logic [3:0] {
    CMD_HOME    = 4'd0,
    CMD_FORWARD = 4'd1,
    CMD_BACK    = 4'd2,
    CMD_UP      = 4'd3,
    CMD_DOWN    = 4'd4,
    CMD_END     = 4'd5,
    CMD_MOVE    = 4'd6,
    CMD_READ_AT = 4'd7,
    CMD_WRITE   = 4'd8,
    CMD_CLEAR   = 4'd9,
    CMD_READ    = 4'd10
  } cmd_t;

endpackage

// ===== src/text_screen_cursor_buffer.sv =====
// ----------------------------------------------------------------------------
// text_screen_cursor_buffer
// Character screen buffer with a linear cursor, held in one cell memory.
//
//   channel  signals                                         handshake
//   command  start, command, row_number, col_number,         start & !busy
//            char_value
//   result   done, read_char, cursor_pos, range_error,       done (one cycle)
//            null_ignored
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data       cfg_valid & cfg_ready
//
// A command passes through the calc and exec states before its result is
// shown; a new command may be accepted in the cycle its predecessor's result
// is shown. Clear writes each cell in use (height * width) in turn via the
// single memory port. After reset a fill sweep writes all MAX_ROWS * MAX_COLS
// cells (4096 by default), with busy high. Results cannot be held off.
// ----------------------------------------------------------------------------
module text_screen_cursor_buffer import tscb_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command,
  input  logic [5:0]  row_number,
  input  logic [7:0]  col_number,
  input  logic [7:0]  char_value,
  output logic        done,
  output logic [7:0]  read_char,
  output logic [11:0] cursor_pos,
  output logic        range_error,
  output logic        null_ignored,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [5:0]    height;
  logic [7:0]    width;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [7:0]    mem_rdata;

  assign cfg_ready = 1'b1;

  // Take configuration beats; the background character only matters at
  // reset, so a write to it is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      height <= RESET_HEIGHT;
      width  <= RESET_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HEIGHT: height <= cfg_data[5:0];
        CFG_WIDTH:  width  <= cfg_data;
        default:    height <= height;
      endcase
    end
  end

  tscb_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .CELLS    (CELLS),
    .AW       (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .row_number   (row_number),
    .col_number   (col_number),
    .char_value   (char_value),
    .height       (height),
    .width        (width),
    .mem_addr     (mem_addr),
    .mem_we       (mem_we),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_rdata    (mem_rdata),
    .done         (done),
    .read_char    (read_char),
    .cursor_pos   (cursor_pos),
    .range_error  (range_error),
    .null_ignored (null_ignored)
  );

  tscb_store #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .re    (mem_re),
    .rdata (mem_rdata)
  );

endmodule

// ===== src/tscb_store.sv =====
// ----------------------------------------------------------------------------
// tscb_store
// Character cell memory: one shared address, synchronous write, registered
// read.
// ----------------------------------------------------------------------------
module tscb_store import tscb_pkg::*; #(
  parameter int CELLS = DEF_MAX_ROWS * DEF_MAX_COLS,
  parameter int AW    = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic [7:0]    wdata,
  input  logic          re,
  output logic [7:0]    rdata
);

  logic [7:0] mem [CELLS];

  // Write the cell, or capture the cell for the next cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== src/tscb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tscb_ctrl
// Command sequencer: clamps the screen size, works out move targets, updates
// the cursor and drives the cell memory, including the fill sweeps.
// ----------------------------------------------------------------------------
module tscb_ctrl import tscb_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int CELLS    = MAX_ROWS * MAX_COLS,
  parameter int AW       = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [3:0]    command,
  input  logic [5:0]    row_number,
  input  logic [7:0]    col_number,
  input  logic [7:0]    char_value,
  input  logic [5:0]    height,
  input  logic [7:0]    width,
  output logic [AW-1:0] mem_addr,
  output logic          mem_we,
  output logic [7:0]    mem_wdata,
  output logic          mem_re,
  input  logic [7:0]    mem_rdata,
  output logic          done,
  output logic [7:0]    read_char,
  output logic [11:0]   cursor_pos,
  output logic          range_error,
  output logic          null_ignored
);

  localparam int SW = $clog2(CELLS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int PW = 6 + CW;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CALC  = 6'b000100,
    S_EXEC  = 6'b001000,
    S_CLEAR = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t        state, state_next;
  logic [AW-1:0] cnt;
  logic [AW-1:0] cursor;
  cmd_t          cmd_q;
  logic [5:0]    row_q;
  logic [7:0]    col_q;
  logic [7:0]    ch_q;
  logic [SW-1:0] size_q;
  logic [CW-1:0] w_q;
  logic [AW-1:0] target_q;
  logic          rerr_q;
  logic          rd_flag;
  logic          accept;

  logic [RW-1:0]    h_eff;
  logic [CW-1:0]    w_eff;
  logic [RW+CW-1:0] size_prod;
  logic [5:0]       row_m1;
  logic [PW-1:0]    row_prod;
  logic [PW:0]      target_sum;
  logic             calc_rerr;
  logic [SW-1:0]    c0;
  logic [SW-1:0]    wz;
  logic [SW-1:0]    nxt;

  assign accept = start && !busy;
  assign busy   = !(state == S_IDLE || state == S_RESP);
  assign done   = (state == S_RESP);

  // Clamp the screen size to the stored range
  always_comb begin
    if (height == '0) begin
      h_eff = RW'(1);
    end else if (32'(height) > 32'(MAX_ROWS)) begin
      h_eff = RW'(MAX_ROWS);
    end else begin
      h_eff = RW'(height);
    end
    if (width == '0) begin
      w_eff = CW'(1);
    end else if (32'(width) > 32'(MAX_COLS)) begin
      w_eff = CW'(MAX_COLS);
    end else begin
      w_eff = CW'(width);
    end
  end

  // Screen size and absolute target
  always_comb begin
    size_prod  = (RW+CW)'(h_eff) * (RW+CW)'(w_eff);
    row_m1     = row_q - 6'd1;
    row_prod   = PW'(row_m1) * PW'(w_eff);
    target_sum = (PW+1)'(row_prod) + (PW+1)'(col_q) - (PW+1)'(1);
    calc_rerr  = (row_q == '0) || (32'(row_q) > 32'(h_eff)) ||
                 (col_q == '0) || (32'(col_q) > 32'(w_eff));
  end

  // Next cursor from the command
  always_comb begin
    c0 = (SW'(cursor) >= size_q) ? '0 : SW'(cursor);
    wz = SW'(w_q);
    case (cmd_q) inside
      CMD_HOME:    nxt = '0;
      CMD_FORWARD: nxt = (c0 + SW'(1) >= size_q) ? '0 : c0 + SW'(1);
      CMD_BACK:    nxt = (c0 == '0) ? size_q - SW'(1) : c0 - SW'(1);
      CMD_UP:      nxt = (c0 < wz) ? size_q - wz + c0 : c0 - wz;
      CMD_DOWN:    nxt = (c0 >= size_q - wz) ? c0 + wz - size_q : c0 + wz;
      CMD_END:     nxt = size_q - SW'(1);
      CMD_MOVE, CMD_READ_AT: nxt = rerr_q ? c0 : SW'(target_q);
      CMD_CLEAR:   nxt = '0;
      default:     nxt = c0;
    endcase
  end

  // Drive the cell memory
  always_comb begin
    mem_addr  = AW'(nxt);
    mem_wdata = ch_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    unique case (state)
      S_INIT: begin
        mem_addr  = cnt;
        mem_wdata = RESET_BG;
        mem_we    = 1'b1;
      end
      S_CLEAR: begin
        mem_addr = cnt;
        mem_we   = 1'b1;
      end
      S_EXEC: begin
        mem_we = (cmd_q == CMD_WRITE) && (ch_q != NUL_CHAR);
        mem_re = (cmd_q == CMD_READ) || (cmd_q == CMD_READ_AT);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequence the command
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:  state_next = (32'(cnt) == CELLS - 1) ? S_IDLE : S_INIT;
      S_IDLE:  state_next = accept ? S_CALC : S_IDLE;
      S_CALC:  state_next = S_EXEC;
      S_EXEC:  state_next = (cmd_q == CMD_CLEAR) ? S_CLEAR : S_RESP;
      S_CLEAR: state_next = (SW'(cnt) == size_q - SW'(1)) ? S_RESP : S_CLEAR;
      S_RESP:  state_next = accept ? S_CALC : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      cnt    <= '0;
      cursor <= '0;
    end else begin
      state <= state_next;
      if (state == S_INIT || state == S_CLEAR) begin
        cnt <= cnt + AW'(1);
      end else begin
        cnt <= '0;
      end
      if (state == S_EXEC) begin
        cursor <= AW'(nxt);
      end
    end
  end

  // Hold the command beat and the per-command results
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(command);
      row_q <= row_number;
      col_q <= col_number;
      ch_q  <= char_value;
    end
    if (state == S_CALC) begin
      size_q   <= SW'(size_prod);
      w_q      <= w_eff;
      target_q <= AW'(target_sum);
      rerr_q   <= calc_rerr;
    end
    if (state == S_EXEC) begin
      rd_flag      <= (cmd_q == CMD_READ) || (cmd_q == CMD_READ_AT);
      range_error  <= ((cmd_q == CMD_MOVE) || (cmd_q == CMD_READ_AT)) && rerr_q;
      null_ignored <= (cmd_q == CMD_WRITE) && (ch_q == NUL_CHAR);
    end
  end

  assign read_char  = rd_flag ? mem_rdata : 8'd0;
  assign cursor_pos = 12'(cursor);

endmodule
